### design/shbh_pkg.sv
`default_nettype none
package shbh_pkg;

    localparam int unsigned CNT_W = 29;
    localparam logic [CNT_W-1:0] MAX_BYTES = 29'd536870911;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        too_long;
    } t_out_item;

    // classified transaction passed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic             ovf;
        logic             last;
        logic             has;
        logic [7:0]       data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_OUT
    } t_bstate;

    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        logic [31:0] r;
        unique case (idx)
            3'd0: r = 32'hc1059ed8;
            3'd1: r = 32'h367cd507;
            3'd2: r = 32'h3070dd17;
            3'd3: r = 32'hf70e5939;
            3'd4: r = 32'hffc00b31;
            3'd5: r = 32'h68581511;
            3'd6: r = 32'h64f98fa7;
            default: r = 32'hbefa4fa4;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[t];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

### design/shbh_front.sv
`default_nettype none
module shbh_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire shbh_pkg::t_in_item i_item,
    input  wire shbh_pkg::t_q_stat  i_q_stat,
    output logic                  o_push,
    output shbh_pkg::t_cmd        o_cmd
);
    import shbh_pkg::*;

    logic [CNT_W-1:0] r_total, n_total;
    logic             r_ovf, n_ovf;
    logic             has_eff;
    logic             accept;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;

    always_comb begin
        has_eff = i_item.has_byte && !r_ovf && (r_total != MAX_BYTES);
        n_ovf   = r_ovf || (i_item.has_byte && (r_total == MAX_BYTES));
        n_total = r_total + {{(CNT_W-1){1'b0}}, has_eff};
        // drop transactions that carry neither a byte nor the end mark
        o_push     = accept && (has_eff || i_item.last);
        o_cmd.data  = i_item.data_byte;
        o_cmd.has   = has_eff;
        o_cmd.last  = i_item.last;
        o_cmd.ovf   = n_ovf;
        o_cmd.total = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            if (i_item.last) begin
                r_total <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_total <= n_total;
                r_ovf   <= n_ovf;
            end
        end
    end
endmodule
`default_nettype wire

### design/shbh_queue.sv
`default_nettype none
module shbh_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire shbh_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output shbh_pkg::t_q_stat   o_stat,
    output shbh_pkg::t_cmd      o_cmd
);
    import shbh_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       do_pop;
    logic       do_push;

    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_cmd        = r_mem[r_rptr];
    assign do_pop       = i_pop && o_stat.valid;
    assign do_push      = i_push && !o_stat.full;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

### design/shbh_back.sv
`default_nettype none
module shbh_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire shbh_pkg::t_q_stat i_q_stat,
    input  wire shbh_pkg::t_cmd    i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output shbh_pkg::t_out_item    o_item
);
    import shbh_pkg::*;

    t_bstate     r_state, n_state;
    logic [5:0]  r_pos;
    logic [23:0] r_acc;
    logic [31:0] r_w     [16];
    logic [31:0] r_chain [8];
    logic [31:0] r_v     [8];
    logic [31:0] n_v     [8];
    logic [5:0]  r_round;
    logic        r_pad;
    logic        r_len;
    logic        r_sent80;
    logic        r_final;
    logic        r_err;
    logic [31:0] r_bits;
    logic [2:0]  r_idx;

    logic        feed_en;
    logic [7:0]  feed_byte;
    logic        word_done;
    logic        block_full;
    logic        len_phase;
    logic        out_done;
    logic [31:0] sched;
    logic [31:0] t1;
    logic [31:0] t2;

    assign len_phase  = r_len || (r_sent80 && (r_pos == LEN_POS));
    assign word_done  = feed_en && (r_pos[1:0] == 2'd3);
    assign block_full = feed_en && (r_pos == LAST_POS);
    assign out_done   = !i_stall && (r_err || (r_idx == LAST_IDX));

    always_comb begin
        n_state   = r_state;
        feed_en   = 1'b0;
        feed_byte = i_cmd.data;
        o_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_stat.valid) begin
                    o_pop   = 1'b1;
                    feed_en = i_cmd.has;
                    if (feed_en && (r_pos == LAST_POS)) begin
                        n_state = S_COMP;
                    end else if (i_cmd.last) begin
                        n_state = i_cmd.ovf ? S_OUT : S_PAD;
                    end
                end
            end
            S_PAD: begin
                feed_en = 1'b1;
                if (!r_sent80) begin
                    feed_byte = PAD_BYTE;
                end else if (len_phase && (r_pos[5:2] == 4'hf)) begin
                    feed_byte = r_bits[{~r_pos[1:0], 3'b000} +: 8];
                end else begin
                    feed_byte = 8'h00;
                end
                if (r_pos == LAST_POS) begin
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                if (r_round == LAST_ROUND) begin
                    n_state = r_final ? S_OUT : (r_pad ? S_PAD : S_IDLE);
                end
            end
            S_OUT: begin
                if (out_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // one compression round and one schedule word per cycle
    always_comb begin
        sched = (rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10)) + r_w[9]
              + (rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3)) + r_w[0];
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_round) + r_w[0];
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        n_v[0] = t1 + t2;
        n_v[1] = r_v[0];
        n_v[2] = r_v[1];
        n_v[3] = r_v[2];
        n_v[4] = r_v[3] + t1;
        n_v[5] = r_v[4];
        n_v[6] = r_v[5];
        n_v[7] = r_v[6];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath without reset
    always_ff @(posedge i_clk) begin
        if (feed_en) begin
            r_acc <= {r_acc[15:0], feed_byte};
        end
        if (word_done) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= {r_acc, feed_byte};
        end else if (r_state == S_COMP) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= sched;
        end
        if (block_full) begin
            r_v <= r_chain;
        end else if (r_state == S_COMP) begin
            r_v <= n_v;
        end
        if (o_pop && i_cmd.last) begin
            r_bits <= {i_cmd.total, 3'b000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_round  <= '0;
            r_pad    <= 1'b0;
            r_len    <= 1'b0;
            r_sent80 <= 1'b0;
            r_final  <= 1'b0;
            r_err    <= 1'b0;
            r_idx    <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= iv_word(3'(i));
            end
        end else begin
            if (feed_en) begin
                r_pos <= r_pos + 6'd1;
            end
            if (block_full) begin
                r_round <= '0;
            end else if (r_state == S_COMP) begin
                r_round <= r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + n_v[i];
                    end
                end
            end
            if (o_pop && i_cmd.last) begin
                r_pad <= !i_cmd.ovf;
                r_err <= i_cmd.ovf;
            end
            if (r_state == S_PAD) begin
                r_sent80 <= 1'b1;
                if (len_phase) begin
                    r_len <= 1'b1;
                    if (r_pos == LAST_POS) begin
                        r_final <= 1'b1;
                    end
                end
            end
            if (r_state == S_OUT && !i_stall) begin
                if (out_done) begin
                    // start afresh for the next message
                    r_idx    <= '0;
                    r_pos    <= '0;
                    r_pad    <= 1'b0;
                    r_len    <= 1'b0;
                    r_sent80 <= 1'b0;
                    r_final  <= 1'b0;
                    r_err    <= 1'b0;
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= iv_word(3'(i));
                    end
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    assign o_valid            = (r_state == S_OUT);
    assign o_item.digest_word = r_err ? 32'd0 : r_chain[r_idx];
    assign o_item.word_index  = r_idx;
    assign o_item.last_word   = r_err || (r_idx == LAST_IDX);
    assign o_item.too_long    = r_err;
endmodule
`default_nettype wire

### design/sha224_byte_stream_hasher_unit.sv
`default_nettype none
// SHA-224 hasher fed one message byte per transaction; a transaction with last set ends
// the message (has_byte low hashes the message without a new byte) and seven digest
// words follow, word 0 first. A front stage classifies transactions and counts bytes
// into a two-entry queue; the back end gathers bytes into the 16-word schedule window
// and runs the compression at one round per cycle. A block's bytes are all taken in
// before its rounds run; the end of a message adds 9 to 72 padding bytes, the upper part
// spilling into an extra block, and then the digest words go out. Messages over
// 536870911 bytes give one result with too_long set instead of a digest.
module sha224_byte_stream_hasher_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire shbh_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output shbh_pkg::t_out_item      o_out_item
);
    import shbh_pkg::*;

    t_q_stat q_stat;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    pop;

    shbh_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_item   (i_in_item),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    shbh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_cmd   (head_cmd)
    );

    shbh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_item   (o_out_item)
    );

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.too_long |->
            o_out_item.last_word && (o_out_item.word_index == 3'd0))
        else $error("error result not a single closing transaction");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last_word |=>
            o_out_valid && (o_out_item.word_index == $past(o_out_item.word_index) + 3'd1))
        else $error("digest words out of order");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !(push && !o_in_stall))
        else $error("queue overrun");
endmodule
`default_nettype wire

### verif/tb_sha224_byte_stream_hasher_unit.sv
`default_nettype none
module tb_sha224_byte_stream_hasher_unit;
    import shbh_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    sha224_byte_stream_hasher_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item)
    );

    // hasher state mirrored in the testbench
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    logic [29:0] msg_len;
    logic        len_overflow;

    t_in_item  byte_queue [$];
    t_out_item digest_queue [$];
    int        mismatch_count;
    int        cycle_count;
    bit        stim_done;
    bit        quiet_stretch;

    localparam logic [31:0] SHA224_IV [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };
    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_hasher();
        for (int i = 0; i < 8; i++) hash_state[i] = SHA224_IV[i];
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
        msg_len = '0;
        len_overflow = 1'b0;
    endtask

    task automatic compress_msg_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic hash_byte_item(input t_in_item it);
        t_out_item r;
        int pos;
        logic [31:0] bits;
        if (it.has_byte && !len_overflow) begin
            if (msg_len >= 30'(MAX_BYTES)) begin
                len_overflow = 1'b1;
            end else begin
                msg_block[msg_len[5:0]] = it.data_byte;
                msg_len = msg_len + 30'd1;
                if (msg_len[5:0] == 6'd0) compress_msg_block();
            end
        end
        if (!it.last) return;
        if (len_overflow) begin
            r = '{digest_word: 32'd0, word_index: 3'd0, last_word: 1'b1, too_long: 1'b1};
            digest_queue.push_back(r);
            clear_hasher();
            return;
        end
        pos = int'(msg_len[5:0]);
        msg_block[pos] = PAD_BYTE;
        for (int k = pos + 1; k < 64; k++) msg_block[k] = 8'h00;
        if (pos >= 56) begin
            compress_msg_block();
            for (int k = 0; k < 64; k++) msg_block[k] = 8'h00;
        end
        bits = {msg_len[28:0], 3'b000};
        for (int k = 56; k < 60; k++) msg_block[k] = 8'h00;
        msg_block[60] = bits[31:24];
        msg_block[61] = bits[23:16];
        msg_block[62] = bits[15:8];
        msg_block[63] = bits[7:0];
        compress_msg_block();
        for (int k = 0; k < 7; k++) begin
            r.digest_word = hash_state[k];
            r.word_index = 3'(k);
            r.last_word = (3'(k) == LAST_IDX);
            r.too_long = 1'b0;
            digest_queue.push_back(r);
        end
        clear_hasher();
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic t_in_item mk(input logic [7:0] d, input logic h, input logic l);
        t_in_item it;
        it.data_byte = d;
        it.has_byte = h;
        it.last = l;
        return it;
    endfunction

    task automatic add_message(input int len, input bit empty_end);
        for (int i = 0; i < len; i++)
            byte_queue.push_back(mk(8'($urandom_range(0, 255)), 1'b1,
                                    (i == len - 1) && !empty_end));
        if (empty_end || len == 0) byte_queue.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // stimulus
    initial begin
        int budget;
        clear_hasher();
        mismatch_count = 0;
        stim_done = 1'b0;
        quiet_stretch = 1'b0;
        // directed: empty message, byte extremes, idle item, byte with last
        byte_queue.push_back(mk(8'hff, 1'b0, 1'b1));
        byte_queue.push_back(mk(8'h00, 1'b1, 1'b0));
        byte_queue.push_back(mk(8'h5a, 1'b0, 1'b0));
        byte_queue.push_back(mk(8'hff, 1'b1, 1'b1));
        byte_queue.push_back(mk(8'h61, 1'b1, 1'b0));
        byte_queue.push_back(mk(8'h62, 1'b1, 1'b0));
        byte_queue.push_back(mk(8'h63, 1'b1, 1'b1));
        byte_queue.push_back(mk(8'haa, 1'b1, 1'b0));
        byte_queue.push_back(mk(8'h55, 1'b1, 1'b0));
        byte_queue.push_back(mk(8'h00, 1'b0, 1'b1));
        // random: lengths around block and padding boundaries
        budget = 0;
        while (budget < 160) begin
            int len;
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 3);
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(63, 65);
                3: len = $urandom_range(118, 121);
                default: len = $urandom_range(1, 30);
            endcase
            if ($urandom_range(0, 3) == 0)
                byte_queue.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            add_message(len, $urandom_range(0, 2) == 0);
            budget += len + 1;
        end
        stim_done = 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_item <= '0;
        end else begin
            logic fire;
            fire = i_in_valid && !o_in_stall;
            if (fire) hash_byte_item(i_in_item);
            if (!i_in_valid || fire) begin
                if (byte_queue.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 8)) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= byte_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (digest_queue.size() == 0) begin
                    report_mismatch("unexpected digest transaction");
                end else begin
                    t_out_item exp_item;
                    exp_item = digest_queue.pop_front();
                    if (o_out_item.digest_word !== exp_item.digest_word)
                        report_mismatch($sformatf("digest_word %h, want %h",
                            o_out_item.digest_word, exp_item.digest_word));
                    if (o_out_item.word_index !== exp_item.word_index)
                        report_mismatch($sformatf("word_index %0d, want %0d",
                            o_out_item.word_index, exp_item.word_index));
                    if (o_out_item.last_word !== exp_item.last_word)
                        report_mismatch($sformatf("last_word %b, want %b",
                            o_out_item.last_word, exp_item.last_word));
                    if (o_out_item.too_long !== exp_item.too_long)
                        report_mismatch($sformatf("too_long %b, want %b",
                            o_out_item.too_long, exp_item.too_long));
                end
            end
            i_out_stall <= !quiet_stretch && ($urandom_range(0, 99) < 8);
        end
    end

    // run control
    initial begin
        cycle_count = 0;
        fork
            begin
                @(posedge i_rst_n);
                // hold a stretch with no idling early in the run
                repeat (200) @(posedge i_clk);
                quiet_stretch = 1'b1;
                repeat (1500) @(posedge i_clk);
                quiet_stretch = 1'b0;
            end
            begin
                forever begin
                    @(posedge i_clk);
                    cycle_count++;
                    if (cycle_count >= CYCLE_LIMIT) begin
                        $display("Mismatches found");
                        $finish;
                    end
                end
            end
            begin
                wait (stim_done && byte_queue.size() == 0);
                @(posedge i_clk);
                while (i_in_valid || digest_queue.size() > 0) @(posedge i_clk);
                repeat (300) @(posedge i_clk);
                if (mismatch_count == 0 && digest_queue.size() == 0) begin
                    $display("No mismatches found");
                end else begin
                    $display("Mismatches found");
                end
                $finish;
            end
        join
    end
endmodule
`default_nettype wire

### sha224_byte_stream_hasher_unit.f
design/shbh_pkg.sv
design/shbh_front.sv
design/shbh_queue.sv
design/shbh_back.sv
design/sha224_byte_stream_hasher_unit.sv
verif/tb_sha224_byte_stream_hasher_unit.sv
